// File: hw/rtl/cpf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the CAN packet fragmenter.
// No dependencies; imported by every module of the block.
package cpf_pkg;

    // Packet length limit and derived counter width
    localparam int MAX_LEN = 512;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Frame queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Frame format constants
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  SENDER_OFS    = 8'd128;
    localparam logic [15:0] SHORT_OFS_MAX = 16'd252;
    localparam logic [15:0] SHORT_PKT_MAX = 16'd6;
    localparam logic [2:0]  CHUNK_SHORT   = 3'd7;
    localparam logic [2:0]  CHUNK_LONG    = 3'd6;
    localparam logic [3:0]  PROC_LEN      = 4'd6;

    // Register reset values
    localparam logic [7:0] RST_SENDER_ID      = 8'd0;
    localparam logic [7:0] RST_CODE_FILL      = 8'd5;
    localparam logic [7:0] RST_CODE_FILL_LONG = 8'd6;
    localparam logic [7:0] RST_CODE_PROCESS   = 8'd7;
    localparam logic [7:0] RST_CODE_SHORT     = 8'd8;

    // Register indexes
    typedef enum logic [2:0] {
        REG_SENDER_ID      = 3'd0,
        REG_CODE_FILL      = 3'd1,
        REG_CODE_FILL_LONG = 3'd2,
        REG_CODE_PROCESS   = 3'd3,
        REG_CODE_SHORT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] sender_id;
        logic [7:0] code_fill;
        logic [7:0] code_fill_long;
        logic [7:0] code_process;
        logic [7:0] code_short;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] dest_id;
        logic       send_flag;
    } in_item_t;

    typedef struct packed {
        logic [28:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  frame_b0;
        logic [7:0]  frame_b1;
        logic [7:0]  frame_b2;
        logic [7:0]  frame_b3;
        logic [7:0]  frame_b4;
        logic [7:0]  frame_b5;
        logic [7:0]  frame_b6;
        logic [7:0]  frame_b7;
        logic        run_end;
        logic        overflow;
    } frame_t;

    // Queue write strobes: a is the first frame of an item, b the second
    typedef struct packed {
        logic a;
        logic b;
    } push_t;

    typedef logic [7:0][7:0] fbytes_t;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/cpf_core.sv
// Packet state and frame builder: input register, per-packet counters, chunk buffer, CRC.
// Depends on cpf_pkg. Produces up to two frames per byte for the frame queue.
module cpf_core
    import cpf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    input  logic     q_room,
    output push_t    push,
    output frame_t   frame_a,
    output frame_t   frame_b
);

    // Input register
    logic       in_valid_reg;
    in_item_t   item_reg;

    // Packet state
    logic [CNT_W-1:0] byte_count_reg;
    logic [2:0]       chunk_fill_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       held_dest_reg;
    logic             held_send_reg;
    logic             dropped_reg;
    logic [7:0]       chunk_reg [CHUNK_SHORT];

    logic             go;
    logic             first;
    logic [7:0]       dest_cur;
    logic             send_cur;
    logic             kept;
    logic [CNT_W-1:0] start;
    logic [15:0]      start16;
    logic             long_ofs;
    logic [2:0]       cf1;
    logic [CNT_W-1:0] bc1;
    logic [15:0]      bc16;
    logic [15:0]      crc1;
    logic             drop1;
    logic [7:0]       cm [CHUNK_SHORT];
    logic             cap_hit;
    logic             is_last;
    logic             short_pkt;
    logic             has_flush;
    fbytes_t          fill_b;
    fbytes_t          fin_b;
    logic [3:0]       fill_len;
    logic [3:0]       fin_len;
    logic [7:0]       fill_code;
    logic [7:0]       fin_code;
    frame_t           fill_frame;
    frame_t           fin_frame;

    function automatic frame_t make_frame(input logic [7:0] dest, input logic [7:0] code,
                                          input logic [3:0] len, input fbytes_t b,
                                          input logic ovf, input logic rend);
        frame_t f;
        f.frame_id  = {13'd0, code, dest};
        f.frame_len = len;
        f.frame_b0  = b[0];
        f.frame_b1  = b[1];
        f.frame_b2  = b[2];
        f.frame_b3  = b[3];
        f.frame_b4  = b[4];
        f.frame_b5  = b[5];
        f.frame_b6  = b[6];
        f.frame_b7  = b[7];
        f.run_end   = rend;
        f.overflow  = ovf;
        return f;
    endfunction

    // Handshake: a held item moves on whenever the queue has room for two frames
    assign go       = in_valid_reg && q_room;
    assign in_stall = in_valid_reg && !q_room;

    // Per-byte update
    always_comb
    begin
        first    = (byte_count_reg == '0);
        dest_cur = first ? item_reg.dest_id : held_dest_reg;
        send_cur = first ? item_reg.send_flag : held_send_reg;
        kept     = (byte_count_reg < CNT_W'(MAX_LEN));
        start    = byte_count_reg - CNT_W'(chunk_fill_reg);
        start16  = 16'(start);
        long_ofs = (start16 > SHORT_OFS_MAX);
        cf1      = kept ? (chunk_fill_reg + 3'd1) : chunk_fill_reg;
        bc1      = kept ? (byte_count_reg + CNT_W'(1)) : byte_count_reg;
        bc16     = 16'(bc1);
        crc1     = kept ? crc16_byte(crc_reg, item_reg.data_byte) : crc_reg;
        drop1    = dropped_reg || !kept;
        for (int i = 0; i < CHUNK_SHORT; i++)
        begin
            cm[i] = (kept && chunk_fill_reg == 3'(i)) ? item_reg.data_byte : chunk_reg[i];
        end
        cap_hit   = kept && (long_ofs ? (cf1 == CHUNK_LONG) : (cf1 == CHUNK_SHORT));
        is_last   = item_reg.last_byte;
        short_pkt = (bc16 <= SHORT_PKT_MAX);
        has_flush = cap_hit || (is_last && !short_pkt && cf1 != 3'd0);
    end

    // Fill frame: offset header then the chunk
    always_comb
    begin
        fill_b = '0;
        if (!long_ofs)
        begin
            fill_b[0] = start16[7:0];
            for (int i = 0; i < 7; i++)
            begin
                if (3'(i) < cf1)
                    fill_b[1 + i] = cm[i];
            end
            fill_len  = {1'b0, cf1} + 4'd1;
            fill_code = cfg.code_fill;
        end
        else
        begin
            fill_b[0] = start16[15:8];
            fill_b[1] = start16[7:0];
            for (int i = 0; i < 6; i++)
            begin
                if (3'(i) < cf1)
                    fill_b[2 + i] = cm[i];
            end
            fill_len  = {1'b0, cf1} + 4'd2;
            fill_code = cfg.code_fill_long;
        end
    end

    // Closing frame: short packet or process frame
    always_comb
    begin
        fin_b    = '0;
        fin_b[0] = cfg.sender_id + SENDER_OFS;
        fin_b[1] = {7'd0, send_cur};
        if (short_pkt)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (3'(i) < cf1)
                    fin_b[2 + i] = cm[i];
            end
            fin_len  = {1'b0, bc1[2:0]} + 4'd2;
            fin_code = cfg.code_short;
        end
        else
        begin
            fin_b[2] = bc16[15:8];
            fin_b[3] = bc16[7:0];
            fin_b[4] = crc1[15:8];
            fin_b[5] = crc1[7:0];
            fin_len  = PROC_LEN;
            fin_code = cfg.code_process;
        end
    end

    // Frame selection toward the queue
    always_comb
    begin
        fill_frame = make_frame(dest_cur, fill_code, fill_len, fill_b, drop1, !is_last);
        fin_frame  = make_frame(dest_cur, fin_code, fin_len, fin_b, drop1, 1'b1);
        frame_a    = has_flush ? fill_frame : fin_frame;
        frame_b    = fin_frame;
        push.a     = go && (has_flush || is_last);
        push.b     = go && has_flush && is_last;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
    end

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            chunk_fill_reg <= '0;
            crc_reg        <= '0;
            held_dest_reg  <= '0;
            held_send_reg  <= 1'b0;
            dropped_reg    <= 1'b0;
        end
        else if (go)
        begin
            held_dest_reg  <= dest_cur;
            held_send_reg  <= send_cur;
            byte_count_reg <= is_last ? '0 : bc1;
            chunk_fill_reg <= (is_last || cap_hit) ? 3'd0 : cf1;
            crc_reg        <= is_last ? 16'd0 : crc1;
            dropped_reg    <= is_last ? 1'b0 : drop1;
        end
    end

    // Chunk buffer, written at the current fill position
    always_ff @(posedge clk)
    begin
        if (go && kept)
            chunk_reg[chunk_fill_reg] <= item_reg.data_byte;
    end

    // Checks
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && item_reg.last_byte |=> byte_count_reg == '0 && chunk_fill_reg == 3'd0)
        else $error("packet state not cleared after last byte");
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_fill_reg < CHUNK_SHORT)
        else $error("chunk not flushed at capacity");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(MAX_LEN))
        else $error("byte count beyond limit");

endmodule

// File: hw/rtl/cpf_frame_queue.sv
// Four-entry frame queue: takes up to two frames a cycle, hands one out a cycle when not stalled.
// Depends on cpf_pkg.
module cpf_frame_queue
    import cpf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    input  frame_t frame_a,
    input  frame_t frame_b,
    output logic   room,
    output logic   out_valid,
    input  logic   out_stall,
    output frame_t out_data
);

    frame_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QCNT_W-1:0]   count_next;
    logic [QCNT_W-1:0]   n_push;
    logic                pop;

    // Occupancy and pointers
    always_comb
    begin
        room        = (count_reg <= QCNT_W'(QDEPTH - 2));
        out_valid   = (count_reg != '0);
        out_data    = mem_reg[rd_ptr_reg];
        pop         = out_valid && !out_stall;
        n_push      = QCNT_W'(push.a) + QCNT_W'(push.b);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.a)
            mem_reg[wr_ptr_reg] <= frame_a;
        if (push.b)
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= frame_b;
    end

    // Checks
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push.a |-> count_reg <= QCNT_W'(QDEPTH - 2))
        else $error("frame pushed without room");
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.b |-> push.a)
        else $error("second frame pushed without first");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[QPTR_W-1:0] == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count and pointers disagree");

endmodule

// File: hw/rtl/can_packet_fragmenter.sv
// CAN packet fragmenter top level: configuration registers, packet core and frame queue.
// An accepted byte waits in the input register until the four-entry queue has room for it.
// Throughput: one byte per cycle while the queue has room; a byte that closes a long
// packet with an open chunk makes two frames, which leave one per cycle unless stalled.
// Reset (rst_n low, asynchronous) empties the queue, clears packet state and loads the
// default command codes; the chunk buffer and queue storage are not cleared.
module can_packet_fragmenter
    import cpf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output frame_t   out_data,
    input  logic     cfg_we,
    input  logic [2:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);

    cfg_t   cfg_reg;
    logic   q_room;
    push_t  push;
    frame_t frame_a;
    frame_t frame_b;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sender_id      <= RST_SENDER_ID;
            cfg_reg.code_fill      <= RST_CODE_FILL;
            cfg_reg.code_fill_long <= RST_CODE_FILL_LONG;
            cfg_reg.code_process   <= RST_CODE_PROCESS;
            cfg_reg.code_short     <= RST_CODE_SHORT;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SENDER_ID:      cfg_reg.sender_id      <= cfg_wdata;
                REG_CODE_FILL:      cfg_reg.code_fill      <= cfg_wdata;
                REG_CODE_FILL_LONG: cfg_reg.code_fill_long <= cfg_wdata;
                REG_CODE_PROCESS:   cfg_reg.code_process   <= cfg_wdata;
                REG_CODE_SHORT:     cfg_reg.code_short     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Packet core
    cpf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_room   (q_room),
        .push     (push),
        .frame_a  (frame_a),
        .frame_b  (frame_b)
    );

    // Frame queue
    cpf_frame_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .frame_a   (frame_a),
        .frame_b   (frame_b),
        .room      (q_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
